// ===== src/i2d_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the integer to decimal ascii converter
// no dependencies
package i2d_pkg;

   localparam int VALUE_BITS        = 64;   // fixed width of the operand field
   localparam int CHAR_BITS         = 6;    // fixed width of the character field
   localparam int MAX_DIGITS_DEF    = 20;
   localparam int VALUE_WIDTH_DEF   = 64;
   localparam int BCD_DIGIT_BITS    = 4;

   localparam logic [CHAR_BITS-1:0]      ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_BITS-1:0]      ASCII_MINUS = 6'd45;
   localparam logic [BCD_DIGIT_BITS-1:0] BCD_FIVE    = 4'd5;
   localparam logic [BCD_DIGIT_BITS-1:0] BCD_THREE   = 4'd3;

   // commands from the sequencer to the shift-add-3 unit
   typedef struct packed {
      logic load;        // take a new magnitude, clear the digits
      logic step;        // one double dabble iteration
      logic digit_shift; // drop the top digit, move the next one up
   } dabble_ctl_type;

endpackage

// ===== src/i2d_req_if.sv =====
`timescale 1ns / 1ps
// request channel: one operand and its signedness mode per beat
// depends on i2d_pkg
interface i2d_req_if
   import i2d_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic                  mode;

   modport source (output valid, value, mode, input ready);
   modport sink   (input valid, value, mode, output ready);
endinterface

// ===== src/i2d_rsp_if.sv =====
`timescale 1ns / 1ps
// response channel: one ascii character per beat, last marks end of text
// depends on i2d_pkg
interface i2d_rsp_if
   import i2d_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] character;
   logic                 last;

   modport source (output valid, character, last, input ready);
   modport sink   (input valid, character, last, output ready);
endinterface

// ===== src/i2d_dabble.sv =====
`timescale 1ns / 1ps
// shift-add-3 unit: binary shift register feeding a packed bcd digit register
// depends on i2d_pkg
module i2d_dabble
   import i2d_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
   input  logic                      clock,
   input  dabble_ctl_type            ctl,
   input  logic [VALUE_WIDTH-1:0]    load_value,
   output logic [BCD_DIGIT_BITS-1:0] top_digit,
   output logic                      wrapped
);

   localparam int BCD_BITS = MAX_DIGITS * BCD_DIGIT_BITS;

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_BITS-1:0]    bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]    bcd_adj;
   logic                   wrap_ff, wrap_in;

   // add 3 to every digit of 5 or more before the doubling
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[i*BCD_DIGIT_BITS +: BCD_DIGIT_BITS] >= BCD_FIVE) begin
            bcd_adj[i*BCD_DIGIT_BITS +: BCD_DIGIT_BITS] =
               bcd_ff[i*BCD_DIGIT_BITS +: BCD_DIGIT_BITS] + BCD_THREE;
         end else begin
            bcd_adj[i*BCD_DIGIT_BITS +: BCD_DIGIT_BITS] =
               bcd_ff[i*BCD_DIGIT_BITS +: BCD_DIGIT_BITS];
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      wrap_in = wrap_ff;
      if (ctl.load) begin
         bin_in  = load_value;
         bcd_in  = '0;
         wrap_in = 1'b0;
      end else if (ctl.step) begin
         // bits leaving the top digit are multiples of 10^MAX_DIGITS
         bin_in  = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in  = {bcd_adj[BCD_BITS-2:0], bin_ff[VALUE_WIDTH-1]};
         wrap_in = wrap_ff | bcd_adj[BCD_BITS-1];
      end else if (ctl.digit_shift) begin
         bcd_in = {bcd_ff[BCD_BITS-BCD_DIGIT_BITS-1:0], {BCD_DIGIT_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      wrap_ff <= wrap_in;
   end

   assign top_digit = bcd_ff[BCD_BITS-1 -: BCD_DIGIT_BITS];
   assign wrapped   = wrap_ff;

endmodule

// ===== src/int64_to_decimal_ascii_top.sv =====
`timescale 1ns / 1ps
// an operand is loaded, takes one double dabble iteration per operand bit, then its
// MAX_DIGITS digit places are scanned top first (after a minus sign if it is negative);
// leading zeros are dropped without a beat; a new operand is accepted only once the
// last character of the previous one is registered, as the single shift-add-3 unit is
// shared, so stalls on the response side hold off the next operand as well
// reset: synchronous, active high; clears the sequencer and the response valid
module int64_to_decimal_ascii_top
   import i2d_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
   input logic      clock,
   input logic      reset,
   i2d_req_if.sink  req,
   i2d_rsp_if.source rsp
);

   localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
   localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);
   localparam logic [BIT_CNT_W-1:0] BIT_LAST  = BIT_CNT_W'(VALUE_WIDTH - 1);
   localparam logic [DIG_CNT_W-1:0] DIG_FULL  = DIG_CNT_W'(MAX_DIGITS);
   localparam logic [DIG_CNT_W-1:0] DIG_FINAL = DIG_CNT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]    dig_cnt_ff, dig_cnt_in;
   logic                    neg_ff, neg_in;
   logic                    started_ff, started_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]    rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   dabble_ctl_type              ctl;
   logic [VALUE_WIDTH-1:0]      operand;
   logic [VALUE_WIDTH-1:0]      magnitude;
   logic                        is_neg;
   logic [BCD_DIGIT_BITS-1:0]   top_digit;
   logic                        wrapped;
   logic                        accept;
   logic                        out_free;
   logic                        digit_shown;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign operand   = req.value[VALUE_WIDTH-1:0];
   assign is_neg    = req.mode && operand[VALUE_WIDTH-1];
   assign magnitude = is_neg ? (~operand + VALUE_WIDTH'(1)) : operand;

   // a digit is printed once the text has started, or it is nonzero, or it is the units
   // digit; a value too big for the digit register prints all of its low digits
   assign digit_shown = started_ff || wrapped || (top_digit != '0) ||
                        (dig_cnt_ff == DIG_FINAL);

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      neg_in       = neg_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      ctl          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctl.load   = 1'b1;
               neg_in     = is_neg;
               bit_cnt_in = BIT_LAST;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            ctl.step   = 1'b1;
            bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
            if (bit_cnt_ff == '0) begin
               dig_cnt_in = DIG_FULL;
               started_in = 1'b0;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (neg_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = ASCII_MINUS;
                  rsp_last_in  = 1'b0;
                  neg_in       = 1'b0;
               end
            end else if (!digit_shown || out_free) begin
               ctl.digit_shift = 1'b1;
               dig_cnt_in      = dig_cnt_ff - DIG_CNT_W'(1);
               if (digit_shown) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = ASCII_ZERO + CHAR_BITS'(top_digit);
                  rsp_last_in  = (dig_cnt_ff == DIG_FINAL);
                  started_in   = 1'b1;
               end
               if (dig_cnt_ff == DIG_FINAL) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         neg_ff       <= 1'b0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         neg_ff       <= neg_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   i2d_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_dabble (
      .clock      (clock),
      .ctl        (ctl),
      .load_value (magnitude),
      .top_digit  (top_digit),
      .wrapped    (wrapped)
   );

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.character = rsp_char_ff;
   assign rsp.last      = rsp_last_ff;

   // a new operand always starts a full conversion pass
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CONVERT) && (bit_cnt_ff == BIT_LAST))
      else $error("conversion did not start after accepted beat");

   // the last shift hands over to digit output
   a_convert_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT) && (bit_cnt_ff == '0) |=> (state_ff == ST_EMIT))
      else $error("conversion did not hand over to emit");

   // the sign is never the final character
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_char_ff == ASCII_MINUS)) |-> !rsp_last_ff)
      else $error("minus sign marked last");

   // digit counter never runs out while emitting
   a_digits_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (dig_cnt_ff != '0))
      else $error("digit counter empty in emit");

endmodule

// ===== sim/int64_to_decimal_ascii_top_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for int64_to_decimal_ascii_top: table-driven edge cases, then random operands
// depends on i2d_pkg, i2d_req_if, i2d_rsp_if and the converter top level
module int64_to_decimal_ascii_top_tb;
   import i2d_pkg::*;

   localparam int DIRECTED_ROWS  = 20;
   localparam int RANDOM_ITEMS   = 100;
   localparam int IDLE_PERCENT   = 13;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = VALUE_WIDTH_DEF + MAX_DIGITS_DEF + 20;

   typedef struct packed {
      logic [CHAR_BITS-1:0] character;
      logic                 last;
   } text_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   i2d_req_if req_ch ();
   i2d_rsp_if rsp_ch ();

   int64_to_decimal_ascii_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #5 clock = ~clock;

   text_beat_type expected_chars [$];
   int         failures       = 0;
   int         chars_checked  = 0;
   int         operands_sent  = 0;
   int         idle_cycles    = 0;
   bit         no_idle        = 1'b0;
   bit         holdoff_request = 1'b0;
   int         holdoff_left   = 0;

   // edge cases; an empty text means the predictor supplies the characters
   logic [VALUE_BITS-1:0] row_value [DIRECTED_ROWS] = '{
      64'd0, 64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
      64'd10000000000000000000, 64'd9999999999999999999,
      64'hFFFF_FFFF_FFFF_FFF6,
      64'hDEAD_BEEF_0123_4567, 64'hDEAD_BEEF_0123_4567,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA
   };
   bit row_mode [DIRECTED_ROWS] = '{
      1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b1, 1'b1, 1'b1
   };
   string row_text [DIRECTED_ROWS] = '{
      "0", "0", "1", "9", "10", "99", "100",
      "18446744073709551615", "-1",
      "-9223372036854775808", "9223372036854775808",
      "9223372036854775807", "9223372036854775807",
      "10000000000000000000", "9999999999999999999",
      "-10", "", "", "", ""
   };

   function automatic void predict_decimal_text(input logic [VALUE_BITS-1:0] operand,
                                                input logic signed_mode);
      logic [VALUE_BITS-1:0]     magnitude;
      logic [BCD_DIGIT_BITS-1:0] digit_stack [MAX_DIGITS_DEF];
      int                        count;
      magnitude = operand;
      count = 0;
      if (signed_mode && operand[VALUE_WIDTH_DEF-1]) begin
         expected_chars.push_back(text_beat_type'{ASCII_MINUS, 1'b0});
         magnitude = ~operand + 1'b1;
      end
      // low digit first; the digit register wraps away anything above MAX_DIGITS
      do begin
         digit_stack[count] = BCD_DIGIT_BITS'(magnitude % 10);
         magnitude = magnitude / 10;
         count++;
      end while (magnitude != 0 && count < MAX_DIGITS_DEF);
      for (int k = count - 1; k >= 0; k--)
         expected_chars.push_back(text_beat_type'{ASCII_ZERO + CHAR_BITS'(digit_stack[k]),
                                                  k == 0});
   endfunction

   function automatic void queue_literal_text(input string text);
      byte letter;
      for (int i = 0; i < text.len(); i++) begin
         letter = text[i];
         expected_chars.push_back(text_beat_type'{letter[CHAR_BITS-1:0],
                                                  i == text.len() - 1});
      end
   endfunction

   function automatic logic [VALUE_BITS-1:0] random_operand();
      logic [VALUE_BITS-1:0] operand;
      operand = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: ;
         1: operand = operand >> $urandom_range(0, VALUE_BITS - 1);
         2: operand = VALUE_BITS'($urandom_range(0, 999));
         3: begin
            // around a power of ten, where the digit count changes
            operand = 64'd1;
            repeat ($urandom_range(0, 19)) operand = operand * 10;
            operand = operand + VALUE_BITS'($urandom_range(0, 2)) - 1;
         end
         4: operand = -VALUE_BITS'($urandom_range(1, 1000));
         default: operand[VALUE_BITS-1] = 1'b1;
      endcase
      return operand;
   endfunction

   task automatic send_operand(input logic [VALUE_BITS-1:0] operand, input logic signed_mode,
                               input string text);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= operand;
      req_ch.mode  <= signed_mode;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (text.len() == 0)
         predict_decimal_text(operand, signed_mode);
      else
         queue_literal_text(text);
      operands_sent++;
   endtask

   // result side: check each beat, then pick ready for the next cycle
   initial begin
      text_beat_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected character beat %0d last %0b", $time,
                        rsp_ch.character, rsp_ch.last);
               failures++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_ch.character !== want.character) begin
                  $display("%0t: character mismatch, expected %0d actual %0d", $time,
                           want.character, rsp_ch.character);
                  failures++;
               end
               if (rsp_ch.last !== want.last) begin
                  $display("%0t: last mismatch, expected %0b actual %0b", $time,
                           want.last, rsp_ch.last);
                  failures++;
               end
            end
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ch.ready <= 1'b0;
         end else if (holdoff_request) begin
            holdoff_request = 1'b0;
            holdoff_left = HOLDOFF_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // ends the run when neither channel moves a beat for too long
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no progress for %0d cycles, %0d characters still expected", $time,
               WATCHDOG_LIMIT, expected_chars.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.value <= '0;
      req_ch.mode  <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_operand(row_value[r], row_mode[r], row_text[r]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_idle = (n >= 30 && n < 60);
         // output stalled for a long stretch while operands keep being offered
         if (n == 80) holdoff_request = 1'b1;
         send_operand(random_operand(), 1'($urandom_range(0, 1)), "");
      end
      req_ch.valid <= 1'b0;

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("converted %0d operands (%0d from the edge-case table), %0d characters checked",
               operands_sent, DIRECTED_ROWS, chars_checked);
      $display("signed and unsigned modes, extremes, powers of ten, stalls on both sides");
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
src/i2d_pkg.sv
src/i2d_req_if.sv
src/i2d_rsp_if.sv
src/i2d_dabble.sv
src/int64_to_decimal_ascii_top.sv
sim/int64_to_decimal_ascii_top_tb.sv
